// ----- src/lru_group_cache_directory_top_defines.svh -----
// Assertion macros shared by the cache directory RTL.
`ifndef LRU_GROUP_CACHE_DIRECTORY_TOP_DEFINES_SVH
`define LRU_GROUP_CACHE_DIRECTORY_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define LGCD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define LGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lgcd_pkg.sv -----
// Types, codes and defaults shared by the cache directory RTL.
`timescale 1ns / 1ps
`default_nettype none
package lgcd_pkg;

  localparam int SLOTS_DEF    = 8;
  localparam int TAG_BITS_DEF = 20;

  localparam int ID_W     = 20;
  localparam int LIMIT_W  = 21;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 3;
  localparam int COUNT_W  = 4;
  localparam int TOTAL_W  = 32;
  localparam int APB_W    = 32;
  localparam int PADDR_W  = 3;

  // Register index, taken from paddr[2].
  localparam logic REG_GROUP_LIMIT = 1'b0;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FILL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAIL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] group_id;
    logic            fetch_ok;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [ID_W-1:0]     evicted_group;
    logic [COUNT_W-1:0]  resident_count;
    logic [TOTAL_W-1:0]  hit_total;
    logic [TOTAL_W-1:0]  miss_total;
    logic [TOTAL_W-1:0]  build_total;
    logic [TOTAL_W-1:0]  evict_total;
  } out_item_t;

endpackage
`default_nettype wire

// ----- src/lgcd_ram.sv -----
// Generic single-port-write RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lgcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/lru_group_cache_directory_top.sv -----
// Top level of the fully associative LRU directory for cached data groups.
// Requests are taken one at a time: a shared tag/rank compare walks the slot RAMs,
//   with a read and a compare step per slot for lookup and a read and a write step
//   per slot for the recency update.
// Reset (rst_n low, synchronous): directory empty, counters and group_limit zero.
// Slot tag and rank RAMs need no clearing: only slots below the fill count are read.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_group_cache_directory_top_defines.svh"
module lru_group_cache_directory_top #(
  parameter int SLOTS    = lgcd_pkg::SLOTS_DEF,
  parameter int TAG_BITS = lgcd_pkg::TAG_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Request channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire lgcd_pkg::in_item_t           in_data,
  // Result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output lgcd_pkg::out_item_t               out_data,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lgcd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [lgcd_pkg::APB_W-1:0]   pwdata,
  output logic      [lgcd_pkg::APB_W-1:0]   prdata,
  output logic                              pready
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot address / rank
  localparam int CNT_W = $clog2(SLOTS + 1);                // fill count, 0..SLOTS

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CMP = 3'd2;
  localparam logic [2:0] S_DECIDE   = 3'd3;
  localparam logic [2:0] S_TOUCH_RD = 3'd4;
  localparam logic [2:0] S_TOUCH_WR = 3'd5;
  localparam logic [2:0] S_WRITE    = 3'd6;
  localparam logic [2:0] S_RESULT   = 3'd7;

  localparam logic [lgcd_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

  // ---------------------------------------------------------------------------
  // Configuration: group_limit where paddr[2] is 0, anything else reads as zero.
  // ---------------------------------------------------------------------------
  logic [lgcd_pkg::LIMIT_W-1:0] limit_r;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == lgcd_pkg::REG_GROUP_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_wr) begin
      limit_r <= pwdata[lgcd_pkg::LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lgcd_pkg::REG_GROUP_LIMIT) begin
      prdata = lgcd_pkg::APB_W'(limit_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------------
  logic [2:0]                         state_r, state_nxt;
  logic [CNT_W-1:0]                   idx_r, idx_nxt;      // slot walker
  logic [CNT_W-1:0]                   occ_r, occ_nxt;      // resident groups
  logic [lgcd_pkg::TOTAL_W-1:0]       hits_r, hits_nxt;
  logic [lgcd_pkg::TOTAL_W-1:0]       misses_r, misses_nxt;
  logic [lgcd_pkg::TOTAL_W-1:0]       builds_r, builds_nxt;
  logic [lgcd_pkg::TOTAL_W-1:0]       evicts_r, evicts_nxt;
  logic                               out_valid_r, out_valid_nxt;
  lgcd_pkg::out_item_t                out_data_r, out_data_nxt;

  // Per-request working registers (payload, no reset)
  logic [lgcd_pkg::ID_W-1:0]          id_r, id_nxt;
  logic                               ok_r, ok_nxt;
  logic                               found_r, found_nxt;
  logic [IDX_W-1:0]                   hit_slot_r, hit_slot_nxt;
  logic [IDX_W-1:0]                   hit_rank_r, hit_rank_nxt;
  logic [IDX_W-1:0]                   lru_slot_r, lru_slot_nxt;
  logic [TAG_BITS-1:0]                lru_tag_r, lru_tag_nxt;
  logic [IDX_W-1:0]                   slot_r, slot_nxt;
  logic [CNT_W-1:0]                   below_r, below_nxt;
  logic [lgcd_pkg::STATUS_W-1:0]      status_r, status_nxt;
  logic                               evicted_r, evicted_nxt;

  // Slot RAM ports
  logic [TAG_BITS-1:0] tag_rdata, tag_wdata;
  logic [IDX_W-1:0]    rank_rdata, rank_wdata;
  logic                tag_we, rank_we;
  logic [IDX_W-1:0]    tag_waddr, rank_waddr, ram_raddr;

  // Shared compare unit: one slot's tag and rank each step
  logic [TAG_BITS-1:0] req_tag;
  logic                tag_match;
  logic                rank_is_lru;
  logic                rank_young;
  logic [CNT_W-1:0]    idx_inc;
  logic                idx_more;
  logic                full;
  logic [31:0]         slot_wide;
  logic [31:0]         occ_wide;

  assign req_tag     = TAG_BITS'(id_r);
  assign tag_match   = (tag_rdata == req_tag);
  assign rank_is_lru = (rank_rdata == IDX_W'(SLOTS - 1));
  assign rank_young  = (CNT_W'(rank_rdata) < below_r);
  assign idx_inc     = idx_r + CNT_W'(1);
  assign idx_more    = (idx_inc < occ_r);
  assign full        = (occ_r == CNT_W'(SLOTS));
  assign ram_raddr   = idx_r[IDX_W-1:0];
  assign slot_wide   = 32'(slot_r);
  assign occ_wide    = 32'(occ_r);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    occ_nxt       = occ_r;
    hits_nxt      = hits_r;
    misses_nxt    = misses_r;
    builds_nxt    = builds_r;
    evicts_nxt    = evicts_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    id_nxt        = id_r;
    ok_nxt        = ok_r;
    found_nxt     = found_r;
    hit_slot_nxt  = hit_slot_r;
    hit_rank_nxt  = hit_rank_r;
    lru_slot_nxt  = lru_slot_r;
    lru_tag_nxt   = lru_tag_r;
    slot_nxt      = slot_r;
    below_nxt     = below_r;
    status_nxt    = status_r;
    evicted_nxt   = evicted_r;
    tag_we        = 1'b0;
    tag_waddr     = slot_r;
    tag_wdata     = req_tag;
    rank_we       = 1'b0;
    rank_waddr    = idx_r[IDX_W-1:0];
    rank_wdata    = rank_rdata + IDX_W'(1);

    // Drop the result once the consumer takes the beat.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          id_nxt      = in_data.group_id;
          ok_nxt      = in_data.fetch_ok;
          found_nxt   = 1'b0;
          evicted_nxt = 1'b0;
          slot_nxt    = '0;
          idx_nxt     = '0;
          state_nxt   = (occ_r == '0) ? S_DECIDE : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        // First matching slot wins; also note the least recent slot.
        if (!found_r && tag_match) begin
          found_nxt    = 1'b1;
          hit_slot_nxt = idx_r[IDX_W-1:0];
          hit_rank_nxt = rank_rdata;
        end
        if (rank_is_lru) begin
          lru_slot_nxt = idx_r[IDX_W-1:0];
          lru_tag_nxt  = tag_rdata;
        end
        if (idx_more) begin
          idx_nxt   = idx_inc;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        idx_nxt = '0;
        if (found_r) begin
          hits_nxt   = (hits_r == TOTAL_MAX) ? hits_r : hits_r + 1'b1;
          status_nxt = lgcd_pkg::ST_HIT;
          slot_nxt   = hit_slot_r;
          below_nxt  = CNT_W'(hit_rank_r);
          state_nxt  = S_TOUCH_RD;
        end else begin
          misses_nxt = (misses_r == TOTAL_MAX) ? misses_r : misses_r + 1'b1;
          if ({1'b0, id_r} >= limit_r) begin
            status_nxt = lgcd_pkg::ST_INVALID;
            state_nxt  = S_RESULT;
          end else if (!ok_r) begin
            status_nxt = lgcd_pkg::ST_FAIL;
            state_nxt  = S_RESULT;
          end else begin
            builds_nxt = (builds_r == TOTAL_MAX) ? builds_r : builds_r + 1'b1;
            status_nxt = lgcd_pkg::ST_FILL;
            below_nxt  = CNT_W'(SLOTS);
            if (full) begin
              slot_nxt    = lru_slot_r;
              evicted_nxt = 1'b1;
              evicts_nxt  = (evicts_r == TOTAL_MAX) ? evicts_r : evicts_r + 1'b1;
              state_nxt   = S_TOUCH_RD;
            end else begin
              slot_nxt  = occ_r[IDX_W-1:0];
              state_nxt = (occ_r == '0) ? S_WRITE : S_TOUCH_RD;
            end
          end
        end
      end
      S_TOUCH_RD: begin
        state_nxt = S_TOUCH_WR;
      end
      S_TOUCH_WR: begin
        // Age every resident entry younger than the touched one.
        rank_we = rank_young;
        if (idx_more) begin
          idx_nxt   = idx_inc;
          state_nxt = S_TOUCH_RD;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        // Touched slot becomes most recent; a fill also lands its tag.
        rank_we    = 1'b1;
        rank_waddr = slot_r;
        rank_wdata = '0;
        if (status_r == lgcd_pkg::ST_FILL) begin
          tag_we = 1'b1;
          if (!evicted_r) begin
            occ_nxt = occ_r + CNT_W'(1);
          end
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.status           = status_r;
          out_data_nxt.slot             = slot_wide[lgcd_pkg::SLOT_W-1:0];
          out_data_nxt.evicted          = evicted_r;
          out_data_nxt.evicted_group    = evicted_r ? lgcd_pkg::ID_W'(lru_tag_r) : '0;
          out_data_nxt.resident_count   = occ_wide[lgcd_pkg::COUNT_W-1:0];
          out_data_nxt.hit_total        = hits_r;
          out_data_nxt.miss_total       = misses_r;
          out_data_nxt.build_total      = builds_r;
          out_data_nxt.evict_total      = evicts_r;
          state_nxt                     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      occ_r       <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      builds_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      occ_r       <= occ_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      builds_r    <= builds_nxt;
      evicts_r    <= evicts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    id_r       <= id_nxt;
    ok_r       <= ok_nxt;
    found_r    <= found_nxt;
    hit_slot_r <= hit_slot_nxt;
    hit_rank_r <= hit_rank_nxt;
    lru_slot_r <= lru_slot_nxt;
    lru_tag_r  <= lru_tag_nxt;
    slot_r     <= slot_nxt;
    below_r    <= below_nxt;
    status_r   <= status_nxt;
    evicted_r  <= evicted_nxt;
  end

  // ---------------------------------------------------------------------------
  // Slot storage
  // ---------------------------------------------------------------------------
  lgcd_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (ram_raddr),
    .rdata (tag_rdata)
  );

  lgcd_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .raddr (ram_raddr),
    .rdata (rank_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LGCD_ASSERT_IMPLY(a_occ_bound, clk, rst_n, 1'b1, occ_r <= CNT_W'(SLOTS),
    "fill count above slot count")
  `LGCD_ASSERT_IMPLY(a_walk_in_range, clk, rst_n,
    (state_r == S_SCAN_RD) || (state_r == S_TOUCH_RD), idx_r < occ_r,
    "slot walker beyond resident entries")
  `LGCD_ASSERT_IMPLY(a_evict_when_full, clk, rst_n,
    out_valid_r && out_data_r.evicted, full,
    "eviction reported while free slots remain")
  `LGCD_ASSERT_NEXT(a_occ_step, clk, rst_n, state_r != S_WRITE, occ_r == $past(occ_r),
    "fill count changed outside the write step")

endmodule
`default_nettype wire

// ----- dv/lru_group_cache_directory_top_tb.sv -----
// Self-checking testbench for the LRU group cache directory: directed steps, then random phases.
`timescale 1ns / 1ps
module lru_group_cache_directory_top_tb;

  localparam int SLOTS    = lgcd_pkg::SLOTS_DEF;
  localparam int ID_W     = lgcd_pkg::ID_W;
  localparam int LIMIT_W  = lgcd_pkg::LIMIT_W;
  localparam int STATUS_W = lgcd_pkg::STATUS_W;
  localparam int SLOT_W   = lgcd_pkg::SLOT_W;
  localparam int COUNT_W  = lgcd_pkg::COUNT_W;
  localparam int TOTAL_W  = lgcd_pkg::TOTAL_W;
  localparam int APB_W    = lgcd_pkg::APB_W;
  localparam int PADDR_W  = lgcd_pkg::PADDR_W;
  // Drain wait sized from the worst request with SLOTS resident groups, with margin.
  localparam int DRAIN_CYCLES = 4 * SLOTS + 8;
  // Cycles with no beat on any port before the run is declared hung.
  localparam int STALL_LIMIT = 5000;
  localparam int POOL_LEN = 12;
  localparam int DIR_LEN = 20;

  // Register map: index in paddr[2], word aligned. The spare index is write-ignored.
  localparam logic SPARE_REG = 1'b1;
  localparam logic [PADDR_W-1:0] LIMIT_ADDR = {lgcd_pkg::REG_GROUP_LIMIT, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = {SPARE_REG, 2'b00};

  typedef enum logic {STEP_REQ, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t          kind;
    logic [PADDR_W-1:0]  addr;
    logic [APB_W-1:0]    value;
    lgcd_pkg::in_item_t  req;
    logic                typed;
    lgcd_pkg::out_item_t want;
  } dir_step_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lgcd_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lgcd_pkg::out_item_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [APB_W-1:0]    pwdata = '0;
  logic [APB_W-1:0]    prdata;
  logic                pready;

  // Directory model: tags and ages per slot, fill count, counters, limit.
  logic [ID_W-1:0]    tag_model [SLOTS];
  int                 rank_model [SLOTS];
  int                 resident = 0;
  logic [TOTAL_W-1:0] hit_count = '0;
  logic [TOTAL_W-1:0] miss_count = '0;
  logic [TOTAL_W-1:0] build_count = '0;
  logic [TOTAL_W-1:0] evict_count = '0;
  logic [LIMIT_W-1:0] limit_model = '0;

  lgcd_pkg::out_item_t pending_results [$];
  lgcd_pkg::out_item_t result_want;
  int                 mismatches = 0;
  int                 stall_cycles = 0;
  int                 snd_idle_pct = 0;
  int                 rcv_idle_pct = 0;
  int                 random_sent = 0;
  dir_step_t          directed_steps [DIR_LEN];

  lru_group_cache_directory_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Age every resident entry younger than 'below', then make 'slot' the newest.
  function automatic void age_entries(int slot, int below);
    for (int i = 0; i < resident; i++) begin
      if (rank_model[i] < below) begin
        rank_model[i]++;
      end
    end
    rank_model[slot] = 0;
  endfunction

  // Advance the directory model by one request and return the result it produces.
  function automatic lgcd_pkg::out_item_t predict_lookup(lgcd_pkg::in_item_t req);
    lgcd_pkg::out_item_t res;
    int        hit_slot;
    int        victim;
    res = '0;
    hit_slot = -1;
    for (int i = 0; i < resident; i++) begin
      if (hit_slot < 0 && tag_model[i] == req.group_id) begin
        hit_slot = i;
      end
    end
    if (hit_slot >= 0) begin
      // Lookup comes before the limit check: a resident group hits even above the limit.
      age_entries(hit_slot, rank_model[hit_slot]);
      hit_count = bump(hit_count);
      res.status = lgcd_pkg::ST_HIT;
      res.slot = SLOT_W'(hit_slot);
    end else begin
      miss_count = bump(miss_count);
      if ({1'b0, req.group_id} >= limit_model) begin
        res.status = lgcd_pkg::ST_INVALID;
      end else if (!req.fetch_ok) begin
        res.status = lgcd_pkg::ST_FAIL;
      end else begin
        build_count = bump(build_count);
        res.status = lgcd_pkg::ST_FILL;
        if (resident < SLOTS) begin
          victim = resident;
          tag_model[victim] = req.group_id;
          age_entries(victim, SLOTS);
          resident++;
        end else begin
          // Full: replace the entry with the oldest age.
          victim = 0;
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (rank_model[i] == SLOTS - 1) begin
              victim = i;
            end
          end
          res.evicted = 1'b1;
          res.evicted_group = tag_model[victim];
          tag_model[victim] = req.group_id;
          age_entries(victim, SLOTS);
          evict_count = bump(evict_count);
        end
        res.slot = SLOT_W'(victim);
      end
    end
    res.resident_count = COUNT_W'(resident);
    res.hit_total = hit_count;
    res.miss_total = miss_count;
    res.build_total = build_count;
    res.evict_total = evict_count;
    return res;
  endfunction

  function automatic dir_step_t req_step(logic [ID_W-1:0] id, logic ok);
    dir_step_t s;
    s = '0;
    s.kind = STEP_REQ;
    s.req.group_id = id;
    s.req.fetch_ok = ok;
    return s;
  endfunction

  // Request with its result typed in; no eviction happens in these rows.
  function automatic dir_step_t checked_step(logic [ID_W-1:0] id, logic ok,
                                             logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl,
                                             logic [COUNT_W-1:0] cnt, int h, int m, int b);
    dir_step_t s;
    s = req_step(id, ok);
    s.typed = 1'b1;
    s.want.status = st;
    s.want.slot = sl;
    s.want.resident_count = cnt;
    s.want.hit_total = TOTAL_W'(h);
    s.want.miss_total = TOTAL_W'(m);
    s.want.build_total = TOTAL_W'(b);
    return s;
  endfunction

  function automatic dir_step_t cfg_step(logic [PADDR_W-1:0] addr, logic [APB_W-1:0] value);
    dir_step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.addr = addr;
    s.value = value;
    return s;
  endfunction

  task automatic check_field(string name, logic [TOTAL_W-1:0] want_v, logic [TOTAL_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Present one request and hold it until the beat; record its result on acceptance.
  task automatic send_request(lgcd_pkg::in_item_t req, logic typed,
                              lgcd_pkg::out_item_t typed_want);
    lgcd_pkg::out_item_t model_out;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    model_out = predict_lookup(req);
    pending_results.insert(pending_results.size(), typed ? typed_want : model_out);
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write (setup, access), then read group_limit back and compare.
  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [APB_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr[2] == lgcd_pkg::REG_GROUP_LIMIT) begin
      limit_model = value[LIMIT_W-1:0];
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LIMIT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("group_limit readback", {{(TOTAL_W-LIMIT_W){1'b0}}, limit_model}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One random phase: settle, write the spare register, program a limit, then mostly requests
  // from a small id pool (so hits and evictions happen), some resident ids and some full-range ids.
  task automatic run_phase(logic [LIMIT_W-1:0] limit, int count);
    logic [ID_W-1:0]    id_pool [POOL_LEN];
    lgcd_pkg::in_item_t req;
    int                 pick;
    drain_results();
    write_reg(SPARE_ADDR, $urandom());
    write_reg(LIMIT_ADDR, APB_W'(limit));
    for (int k = 0; k < POOL_LEN; k++) begin
      if (k < 8 && limit != 0) begin
        id_pool[k] = ID_W'($urandom_range(0, int'(limit) - 1));
      end else begin
        id_pool[k] = ID_W'($urandom());
      end
    end
    repeat (count) begin
      // Sender fast and receiver slow, then the reverse, then no gaps at all.
      if (random_sent < 330) begin
        snd_idle_pct = 12;
        rcv_idle_pct = 85;
      end else if (random_sent < 660) begin
        snd_idle_pct = 85;
        rcv_idle_pct = 12;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30 && resident > 0) begin
        req.group_id = tag_model[$urandom_range(0, resident - 1)];
      end else if (pick < 85) begin
        req.group_id = id_pool[$urandom_range(0, POOL_LEN - 1)];
      end else begin
        req.group_id = ID_W'($urandom());
      end
      req.fetch_ok = ($urandom_range(0, 99) < 80);
      send_request(req, 1'b0, '0);
      random_sent++;
    end
  endtask

  // Result side: check each beat against the oldest expectation, then pick next ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected none actual %h", $time, out_data);
        mismatches++;
      end else begin
        result_want = pending_results.pop_front();
        check_field("status", TOTAL_W'(result_want.status), TOTAL_W'(out_data.status));
        check_field("slot", TOTAL_W'(result_want.slot), TOTAL_W'(out_data.slot));
        check_field("evicted", TOTAL_W'(result_want.evicted), TOTAL_W'(out_data.evicted));
        check_field("evicted_group", TOTAL_W'(result_want.evicted_group),
                    TOTAL_W'(out_data.evicted_group));
        check_field("resident_count", TOTAL_W'(result_want.resident_count),
                    TOTAL_W'(out_data.resident_count));
        check_field("hit_total", result_want.hit_total, out_data.hit_total);
        check_field("miss_total", result_want.miss_total, out_data.miss_total);
        check_field("build_total", result_want.build_total, out_data.build_total);
        check_field("evict_total", result_want.evict_total, out_data.evict_total);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Watchdog: any beat on the request, result or register port restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // Directed part. Typed rows follow reset: limit zero makes everything invalid,
    // then the maximum limit admits every id (the spare write must not disturb it).
    directed_steps = '{
      checked_step(20'h00000, 1'b1, lgcd_pkg::ST_INVALID, 3'd0, 4'd0, 0, 1, 0),
      checked_step(20'hFFFFF, 1'b0, lgcd_pkg::ST_INVALID, 3'd0, 4'd0, 0, 2, 0),
      cfg_step(LIMIT_ADDR, 32'h0010_0000),
      cfg_step(SPARE_ADDR, 32'h0000_0000),
      checked_step(20'hFFFFF, 1'b0, lgcd_pkg::ST_FAIL, 3'd0, 4'd0, 0, 3, 0),
      checked_step(20'hFFFFF, 1'b1, lgcd_pkg::ST_FILL, 3'd0, 4'd1, 0, 4, 1),
      checked_step(20'hFFFFF, 1'b0, lgcd_pkg::ST_HIT, 3'd0, 4'd1, 1, 4, 1),
      // Fill the remaining slots, touch the second-oldest, then force two evictions.
      req_step(20'h00000, 1'b1),
      req_step(20'h55555, 1'b1),
      req_step(20'hAAAAA, 1'b1),
      req_step(20'h00001, 1'b1),
      req_step(20'h00002, 1'b1),
      req_step(20'h00003, 1'b1),
      req_step(20'h00004, 1'b1),
      req_step(20'h00000, 1'b0),
      req_step(20'h12345, 1'b1),
      req_step(20'h54321, 1'b1),
      // Lower the limit: a resident id above it still hits, a new one is invalid.
      cfg_step(LIMIT_ADDR, 32'h0000_0002),
      req_step(20'hAAAAA, 1'b0),
      req_step(20'h80000, 1'b1)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 12;
    rcv_idle_pct = 85;
    foreach (directed_steps[k]) begin
      if (directed_steps[k].kind == STEP_CFG) begin
        drain_results();
        write_reg(directed_steps[k].addr, directed_steps[k].value);
      end else begin
        send_request(directed_steps[k].req, directed_steps[k].typed, directed_steps[k].want);
      end
    end

    // Random phases, each behind a full drain (the sender pauses until all results are in).
    run_phase(21'h100000, 165);
    run_phase(21'h000000, 165);
    run_phase(21'h000001, 165);
    run_phase(21'h0FFFFF, 165);
    run_phase(LIMIT_W'($urandom_range(0, 32'h0010_0000)), 165);
    run_phase(LIMIT_W'($urandom_range(2, 40)), 165);

    drain_results();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
